/* sv/utf8e_pkg.sv */
package utf8e_pkg;

  // Input request: one character or one raw string byte
  typedef struct packed {
    logic [31:0] code_point;
    logic [7:0]  data_byte;
    logic        end_of_string;
  } in_item_t;

  // Output request: one encoded byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Encoded length class of one character
  typedef enum logic [2:0] {
    CLS_ONE   = 3'd0,
    CLS_TWO   = 3'd1,
    CLS_THREE = 3'd2,
    CLS_FOUR  = 3'd3,
    CLS_QMARK = 3'd4
  } cls_e;

  localparam int unsigned CharW = 21;
  localparam int unsigned PosW  = 2;

  // Classified character passed from front to back
  typedef struct packed {
    logic [CharW-1:0] value;
    cls_e             cls;
  } entry_t;

  localparam logic [31:0] MaxOne   = 32'h0000_007F;
  localparam logic [31:0] MaxTwo   = 32'h0000_07FF;
  localparam logic [31:0] MaxThree = 32'h0000_FFFF;
  localparam logic [31:0] MaxFour  = 32'h0010_FFFF;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] QMark     = 8'h3F;

endpackage

/* sv/utf8e_front.sv */
module utf8e_front
  import utf8e_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  input  logic     cfg_ready_i,
  input  logic     cfg_data_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output entry_t   entry_o
);

  logic       fmt_q, fmt_d;
  logic       held_q, held_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic [31:0] word;
  logic        word_ok;

  // Pick the character word and update the pair state
  always_comb begin
    fmt_d       = fmt_q;
    held_d      = held_q;
    held_byte_d = held_byte_q;
    word        = item_i.code_point;
    word_ok     = 1'b0;
    if (cfg_valid_i && cfg_ready_i) begin
      fmt_d = cfg_data_i;
    end
    if (accept_i) begin
      if (!fmt_q) begin
        word_ok = 1'b1;
      end else if (!held_q) begin
        // hold the first byte unless the string ends on it
        if (!item_i.end_of_string) begin
          held_d      = 1'b1;
          held_byte_d = item_i.data_byte;
        end
      end else begin
        word        = {16'h0000, held_byte_q, item_i.data_byte};
        word_ok     = 1'b1;
        held_d      = 1'b0;
        held_byte_d = 8'h00;
      end
    end
  end

  // Classify by encoded length; drop zero
  always_comb begin
    entry_o.value = word[CharW-1:0];
    priority if (word <= MaxOne)   entry_o.cls = CLS_ONE;
    else if     (word <= MaxTwo)   entry_o.cls = CLS_TWO;
    else if     (word <= MaxThree) entry_o.cls = CLS_THREE;
    else if     (word <= MaxFour)  entry_o.cls = CLS_FOUR;
    else                           entry_o.cls = CLS_QMARK;
    push_o = word_ok && (word != 32'h0000_0000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= 1'b0;
      held_q      <= 1'b0;
      held_byte_q <= 8'h00;
    end else begin
      fmt_q       <= fmt_d;
      held_q      <= held_d;
      held_byte_q <= held_byte_d;
    end
  end

endmodule

/* sv/utf8e_fifo.sv */
module utf8e_fifo
  import utf8e_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   nonempty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == FullCnt);
  assign rdata_o    = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* sv/utf8e_back.sv */
module utf8e_back
  import utf8e_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      avail_i,
  input  entry_t    entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic              busy_q, busy_d;
  logic [PosW-1:0]   pos_q, pos_d;
  entry_t            cur_q, cur_d;
  logic [PosW-1:0]   last_pos;
  logic              fire, at_last;
  logic [CharW-1:0]  v;

  assign v = cur_q.value;

  // Index of the final byte for the current class
  always_comb begin
    unique case (cur_q.cls)
      CLS_ONE:   last_pos = 2'd0;
      CLS_TWO:   last_pos = 2'd1;
      CLS_THREE: last_pos = 2'd2;
      CLS_FOUR:  last_pos = 2'd3;
      CLS_QMARK: last_pos = 2'd0;
      default:   last_pos = 2'd0;
    endcase
  end

  assign fire    = busy_q && !out_stall_i;
  assign at_last = (pos_q == last_pos);

  // Build the byte at the current position
  always_comb begin
    out_item_o.out_byte = QMark;
    unique case (cur_q.cls)
      CLS_ONE: out_item_o.out_byte = {1'b0, v[6:0]};
      CLS_TWO: begin
        if (pos_q == 2'd0) out_item_o.out_byte = LeadTwo | {3'b000, v[10:6]};
        else               out_item_o.out_byte = ContMark | {2'b00, v[5:0]};
      end
      CLS_THREE: begin
        unique case (pos_q)
          2'd0:    out_item_o.out_byte = LeadThree | {4'h0, v[15:12]};
          2'd1:    out_item_o.out_byte = ContMark | {2'b00, v[11:6]};
          default: out_item_o.out_byte = ContMark | {2'b00, v[5:0]};
        endcase
      end
      CLS_FOUR: begin
        unique case (pos_q)
          2'd0:    out_item_o.out_byte = LeadFour | {5'h00, v[20:18]};
          2'd1:    out_item_o.out_byte = ContMark | {2'b00, v[17:12]};
          2'd2:    out_item_o.out_byte = ContMark | {2'b00, v[11:6]};
          default: out_item_o.out_byte = ContMark | {2'b00, v[5:0]};
        endcase
      end
      CLS_QMARK: out_item_o.out_byte = QMark;
      default:   out_item_o.out_byte = QMark;
    endcase
    out_item_o.last_of_run = at_last;
  end

  assign out_valid_o = busy_q;

  // Load the next entry when idle or on the final byte, else advance
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    cur_d  = cur_q;
    pop_o  = 1'b0;
    if (!busy_q || (fire && at_last)) begin
      busy_d = avail_i;
      pos_d  = '0;
      cur_d  = entry_i;
      pop_o  = avail_i;
    end else if (fire) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

endmodule

/* sv/utf8_encoder_unit.sv */
// An accepted request is registered in the queue, then in the serializer's entry register.
// Throughput: the single-byte output serializer emits one byte per cycle while out_stall_i
// is low; a character gives 1 to 4 bytes by its UTF-8 length. The front takes one request
// per cycle while the QueueDepth-entry queue between front and serializer has room.
// Reset: rst_ni low clears the format register (code-point mode), the held byte
// and the queue at once; no clearing pass.
module utf8_encoder_unit
  import utf8e_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic   push, pop, avail, full;
  entry_t push_entry, head_entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  // Accept and classify
  utf8e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_valid_i && !in_stall_o),
    .item_i      (in_item_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Decouple front and serializer
  utf8e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (push_entry),
    .pop_i      (pop),
    .rdata_o    (head_entry),
    .nonempty_o (avail),
    .full_o     (full)
  );

  // Emit bytes one per cycle while the output is not stalled
  utf8e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* sv/utf8e_checker.sv */
module utf8e_checker
  import utf8e_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o,
  input logic      cfg_data_i,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // Hold a stalled request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output request dropped or changed while stalled");

  // Never emit a zero byte
  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.out_byte != 8'h00)
    else $error("zero byte emitted");

  // Bytes before the last one of a character are multi-byte bytes
  a_mid_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> out_item_o.out_byte[7])
    else $error("non-final byte has top bit clear");

  // A final byte is never a lead byte
  a_last_not_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_of_run |-> out_item_o.out_byte[7:6] != 2'b11)
    else $error("character ends on a lead byte");

  // A byte after a non-final byte is a continuation byte
  a_cont_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_of_run
      |=> out_valid_o && out_item_o.out_byte[7:6] == 2'b10)
    else $error("character broken before its last byte");

endmodule

bind utf8_encoder_unit utf8e_checker u_utf8e_checker (.*);
